FILE: design/crank_wheel_rpm_meter_assert.svh
// ----------------------------------------------------------------------------
// crank wheel rpm meter assertion macros
// concurrent check wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef CRANK_WHEEL_RPM_METER_ASSERT_SVH
`define CRANK_WHEEL_RPM_METER_ASSERT_SVH

`ifndef SYNTH
`define CRM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CRM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CRM_ASSERT_IMP(lbl, ante, cons, msg)
`define CRM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/crm_pkg.sv
// ----------------------------------------------------------------------------
// crm_pkg
// shared constants, types and helpers of the crank wheel rpm meter
// ----------------------------------------------------------------------------
package crm_pkg;

    localparam int DIV_BITS  = 26;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    localparam logic [DIV_BITS-1:0] US_PER_MIN = DIV_BITS'(60000000);
    localparam logic [15:0] RPM_MAX      = 16'hFFFF;
    localparam logic [15:0] BAND_SPIN_UP = 16'd50;
    localparam logic [15:0] BAND_CRANK   = 16'd400;
    localparam logic [15:0] BAND_RUNNING = 16'd750;
    localparam logic [7:0]  STALL_LIMIT  = 8'd5;
    localparam logic [6:0]  ANGLE_SCALE  = 7'd100;

    localparam logic [7:0]  LAST_TOOTH_RST = 8'd35;
    localparam logic [8:0]  DEG_TOOTH_RST  = 9'd10;
    localparam logic [15:0] WD_PERIOD_RST  = 16'd250;

    localparam logic [1:0] CFG_LAST_TOOTH = 2'd0;
    localparam logic [1:0] CFG_DEG_TOOTH  = 2'd1;
    localparam logic [1:0] CFG_WD_PERIOD  = 2'd2;

    localparam logic FUNC_TOOTH = 1'b0;
    localparam logic FUNC_POLL  = 1'b1;

    localparam logic [1:0] ST_STOPPED = 2'd0;
    localparam logic [1:0] ST_SPIN_UP = 2'd1;
    localparam logic [1:0] ST_CRANK   = 2'd2;
    localparam logic [1:0] ST_RUNNING = 2'd3;

    typedef struct packed {
        logic capture;
        logic exec;
        logic div_wait;
        logic mul;
        logic scale;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic div_busy;
    } t_sts;

    function automatic logic [1:0] classify(input logic [15:0] rpm);
        logic [1:0] code;
        if (rpm < BAND_SPIN_UP) begin
            code = ST_STOPPED;
        end else if (rpm < BAND_CRANK) begin
            code = ST_SPIN_UP;
        end else if (rpm < BAND_RUNNING) begin
            code = ST_CRANK;
        end else begin
            code = ST_RUNNING;
        end
        return code;
    endfunction

endpackage

FILE: design/crm_div.sv
// ----------------------------------------------------------------------------
// crm_div
// radix-2 restoring divider of the microseconds-per-minute constant
// ----------------------------------------------------------------------------
module crm_div
    import crm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_divisor,
    output logic                o_busy,
    output logic                o_done,
    output logic [DIV_BITS-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [31:0]          r_rem;
    logic [DIV_BITS-1:0]  r_q;
    logic [31:0]          r_div;

    logic [32:0]          n_trial;
    logic                 n_ge;
    logic [32:0]          n_diff;

    always_comb begin
        n_trial = {r_rem, r_q[DIV_BITS-1]};
        n_ge    = n_trial >= {1'b0, r_div};
        n_diff  = n_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= US_PER_MIN;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[31:0] : n_trial[31:0];
            r_q   <= {r_q[DIV_BITS-2:0], n_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: design/crm_datapath.sv
// ----------------------------------------------------------------------------
// crm_datapath
// tooth counting, revolution timing, watchdog, angle and result registers
// ----------------------------------------------------------------------------
module crm_datapath
    import crm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_func,
    input  logic [31:0] i_time_us,
    input  logic [31:0] i_time_ms,
    output logic [15:0] o_engine_rpm,
    output logic [1:0]  o_engine_status,
    output logic [15:0] o_crank_angle_x100,
    output logic        o_revolution_done
);

    logic        r_func;
    logic [31:0] r_time_us;
    logic [31:0] r_time_ms;

    logic [7:0]  r_cfg_last;
    logic [8:0]  r_cfg_deg;
    logic [15:0] r_cfg_wd;

    logic [7:0]  r_tooth;
    logic [31:0] r_last_rev;
    logic [15:0] r_rpm;
    logic [1:0]  r_status;
    logic [31:0] r_rev_cnt;
    logic [31:0] r_prev_cnt;
    logic [7:0]  r_stall;
    logic [31:0] r_last_chk;
    logic        r_rev;

    logic [16:0] r_prod;
    logic [15:0] r_angle;

    logic [15:0] r_o_rpm;
    logic [1:0]  r_o_status;
    logic [15:0] r_o_angle;
    logic        r_o_rev;

    logic        w_is_rev;
    logic        w_have_prev;
    logic [31:0] w_period;
    logic        w_wd_due;
    logic        w_stalled;
    logic [23:0] w_scaled;
    logic [15:0] w_div_rpm;

    logic                div_busy;
    logic                div_done;
    logic [DIV_BITS-1:0] div_quot;

    always_comb begin
        w_is_rev    = (r_func == FUNC_TOOTH) && (r_tooth >= r_cfg_last);
        w_have_prev = r_last_rev != 32'd0;
        w_period    = r_time_us - r_last_rev;
        w_wd_due    = (r_func == FUNC_POLL) &&
                      ((r_time_ms - r_last_chk) >= {16'd0, r_cfg_wd});
        w_stalled   = r_rev_cnt == r_prev_cnt;
        w_scaled    = 24'(r_prod) * 24'(ANGLE_SCALE);
        w_div_rpm   = (div_quot[DIV_BITS-1:16] != '0) ? RPM_MAX : div_quot[15:0];
    end

    assign o_sts.need_div = w_is_rev && w_have_prev && (w_period != 32'd0);
    assign o_sts.div_done = div_done;
    assign o_sts.div_busy = div_busy;

    crm_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.exec && o_sts.need_div),
        .i_divisor (w_period),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_last <= LAST_TOOTH_RST;
            r_cfg_deg  <= DEG_TOOTH_RST;
            r_cfg_wd   <= WD_PERIOD_RST;
            r_tooth    <= '0;
            r_last_rev <= '0;
            r_rpm      <= '0;
            r_status   <= ST_STOPPED;
            r_rev_cnt  <= '0;
            r_prev_cnt <= '0;
            r_stall    <= '0;
            r_last_chk <= '0;
            r_rev      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LAST_TOOTH: r_cfg_last <= i_cfg_data[7:0];
                    CFG_DEG_TOOTH:  r_cfg_deg  <= i_cfg_data[8:0];
                    CFG_WD_PERIOD:  r_cfg_wd   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                r_rev <= w_is_rev;
                if (r_func == FUNC_TOOTH) begin
                    if (w_is_rev) begin
                        if (w_have_prev && (w_period == 32'd0)) begin
                            r_rpm    <= RPM_MAX;
                            r_status <= classify(RPM_MAX);
                        end
                        r_last_rev <= r_time_us;
                        r_tooth    <= '0;
                        r_rev_cnt  <= r_rev_cnt + 1'b1;
                    end else begin
                        r_tooth <= r_tooth + 1'b1;
                    end
                end else if (w_wd_due) begin
                    r_last_chk <= r_time_ms;
                    if (w_stalled && (r_stall > STALL_LIMIT)) begin
                        r_rpm      <= '0;
                        r_rev_cnt  <= '0;
                        r_prev_cnt <= '0;
                        r_stall    <= 8'd1;
                    end else if (w_stalled) begin
                        r_stall <= r_stall + 1'b1;
                    end else begin
                        r_prev_cnt <= r_rev_cnt;
                    end
                end
            end
            if (i_cmd.div_wait && div_done) begin
                r_rpm    <= w_div_rpm;
                r_status <= classify(w_div_rpm);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func    <= i_func;
            r_time_us <= i_time_us;
            r_time_ms <= i_time_ms;
        end
        if (i_cmd.mul) begin
            r_prod <= 17'(r_tooth) * 17'(r_cfg_deg);
        end
        if (i_cmd.scale) begin
            r_angle <= (w_scaled[23:16] != '0) ? RPM_MAX : w_scaled[15:0];
        end
        if (i_cmd.load_out) begin
            r_o_rpm    <= r_rpm;
            r_o_status <= r_status;
            r_o_angle  <= r_angle;
            r_o_rev    <= r_rev;
        end
    end

    assign o_engine_rpm       = r_o_rpm;
    assign o_engine_status    = r_o_status;
    assign o_crank_angle_x100 = r_o_angle;
    assign o_revolution_done  = r_o_rev;

endmodule

FILE: design/crm_ctrl.sv
// ----------------------------------------------------------------------------
// crm_ctrl
// sequencing state machine and output valid of the crank wheel rpm meter
// ----------------------------------------------------------------------------
module crm_ctrl
    import crm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_MUL,
        S_SCALE,
        S_PUSH
    } t_state;

    t_state r_state;
    logic   r_valid;
    logic   w_out_free;

    assign w_out_free = !r_valid || !i_stall;

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_valid;
        o_cmd.exec     = r_state == S_EXEC;
        o_cmd.div_wait = r_state == S_DIV;
        o_cmd.mul      = r_state == S_MUL;
        o_cmd.scale    = r_state == S_SCALE;
        o_cmd.load_out = (r_state == S_PUSH) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if ((r_state == S_PUSH) && w_out_free) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= i_sts.need_div ? S_DIV : S_MUL;
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_valid;

endmodule

FILE: design/crank_wheel_rpm_meter.sv
// ----------------------------------------------------------------------------
// crank_wheel_rpm_meter
// each request passes the capture, exec, optional divide, multiply, scale and push states in turn
// o_stall holds off a new request until the result is loaded into the output registers;
//   a timed revolution adds a divide through the 26-step serial divider
// reset: synchronous active low, clears counters and timing state, restores config defaults
// ----------------------------------------------------------------------------
`include "crank_wheel_rpm_meter_assert.svh"

module crank_wheel_rpm_meter
    import crm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [31:0] i_time_us,
    input  logic [31:0] i_time_ms,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_engine_rpm,
    output logic [1:0]  o_engine_status,
    output logic [15:0] o_crank_angle_x100,
    output logic        o_revolution_done,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    crm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    crm_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_func             (i_func),
        .i_time_us          (i_time_us),
        .i_time_ms          (i_time_ms),
        .o_engine_rpm       (o_engine_rpm),
        .o_engine_status    (o_engine_status),
        .o_crank_angle_x100 (o_crank_angle_x100),
        .o_revolution_done  (o_revolution_done)
    );

    `CRM_ASSERT_NXT(a_busy_after_req, i_valid && !o_stall, o_stall, "request not held off")
    `CRM_ASSERT_IMP(a_rev_angle_zero, o_valid && o_revolution_done, o_crank_angle_x100 == 16'd0, "angle not zero on revolution")
    `CRM_ASSERT_IMP(a_idle_div_quiet, !o_stall, !sts.div_busy, "divider busy while idle")

endmodule
